// ===== hw/rtl/hchmm_pkg.sv =====
// shared types and constants for the haplotype-copy hmm forward block
// no dependencies
package hchmm_pkg;

    localparam int CfgPanels = 0;

    typedef struct packed {
        logic [31:0] emission_ref;
        logic [31:0] emission_alt;
        logic [63:0] panel_alleles;
        logic [31:0] switch_prob;
        logic [31:0] stay_prob;
        logic        first_locus;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  hap_index;
        logic [31:0] forward_prob;
        logic        zero_mass;
        logic        last_of_locus;
    } out_item_t;

endpackage

// ===== hw/rtl/haplotype_copy_hmm_forward.sv =====
// haplotype-copy hmm forward pass, one locus per input transfer
// uses hchmm_pkg and hchmm_ram
//
//   channel | direction | handshake      | payload
//   in      | input     | in_valid/ready | hchmm_pkg::in_item_t
//   out     | output    | out_valid/ready| hchmm_pkg::out_item_t
//   cfg     | input     | apb            | panels_in_use at address 0
//
// a continuation locus runs an idle state, a sum pass, a switch-mass step, an
// update pass (four muls per entry on one shared 32x32 multiplier) and a restoring
// divide plus the result per haplotype; a first locus skips sum and mass.
// the store is cleared after reset by a sweep over all entries with in_ready low.
// a stalled output holds the sequencer in its result state; nothing is lost.
module haplotype_copy_hmm_forward #(
    parameter int MAX_PANEL = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hchmm_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hchmm_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import hchmm_pkg::*;

    localparam int AW = $clog2(MAX_PANEL);
    localparam int CW = $clog2(MAX_PANEL + 1);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SUMR = 4'd2,
        S_SUMA = 4'd3, S_MASS = 4'd4, S_RD = 4'd5, S_M1 = 4'd6,
        S_M2 = 4'd7, S_M3 = 4'd8, S_DIVR = 4'd9, S_DIV = 4'd10,
        S_OUT = 4'd11, S_WR = 4'd12, S_M1B = 4'd13, S_M2B = 4'd14;

    logic [3:0]  state_reg;
    logic [6:0]  cfg_reg;
    in_item_t    item_reg;
    logic [AW:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic [37:0] total_reg;
    logic [68:0] mass_reg;
    logic [69:0] term_reg;
    logic [69:0] sum_reg;
    logic [101:0] acc_reg;
    logic [101:0] rem_reg;
    logic [31:0] q_reg;
    logic [5:0]  bit_reg;
    logic        zero_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    // unnormalized values live in a ram; sums of 64 values below 2^102
    logic        vwe;
    logic [AW-1:0] vaddr_w, raddr;
    logic [101:0] vwdata, vrdata;
    logic        fwe;
    logic [31:0] fwdata, frdata;

    hchmm_ram #(.WIDTH(32), .DEPTH(MAX_PANEL)) u_fwd (
        .clk(clk), .we(fwe), .waddr(vaddr_w), .wdata(fwdata),
        .raddr(raddr), .rdata(frdata));
    hchmm_ram #(.WIDTH(102), .DEPTH(MAX_PANEL)) u_val (
        .clk(clk), .we(vwe), .waddr(vaddr_w), .wdata(vwdata),
        .raddr(raddr), .rdata(vrdata));

    // shared 32x32 multiplier
    logic [31:0] ma, mb;
    logic [63:0] mp;
    assign mp = 64'(ma) * 64'(mb);

    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (cfg_reg == 7'd0)
            n_eff = CW'(1);
        else if (cfg_reg > 7'(MAX_PANEL))
            n_eff = CW'(MAX_PANEL);
        else
            n_eff = CW'(cfg_reg);
    end

    logic [AW-1:0] idx;
    assign idx = idx_reg[AW-1:0];
    logic [31:0] em;
    assign em = item_reg.panel_alleles[idx] ? item_reg.emission_alt
                                              : item_reg.emission_ref;

    logic last;
    assign last = (idx_reg + 1'b1) == (AW+1)'(n_reg);

    logic [102:0] trial;
    assign trial = {rem_reg, 1'b0} - {33'd0, sum_reg};

    logic out_ready_ok;
    assign out_ready_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        ma = 32'd0;
        mb = 32'd0;
        unique case (state_reg)
            S_MASS: begin ma = item_reg.switch_prob; mb = {26'd0, total_reg[37:32]}; end
            S_M1:   begin ma = item_reg.stay_prob;   mb = frdata; end
            S_M1B:  begin ma = item_reg.switch_prob; mb = total_reg[31:0]; end
            S_M2:   begin ma = em; mb = term_reg[31:0]; end
            S_M2B:  begin ma = em; mb = term_reg[63:32]; end
            S_M3:   begin ma = em; mb = {26'd0, term_reg[69:64]}; end
            default: ;
        endcase
    end

    assign raddr = (state_reg == S_SUMR || state_reg == S_RD || state_reg == S_DIVR)
                   ? idx : idx;

    always_comb
    begin
        fwe = 1'b0;
        vwe = 1'b0;
        vaddr_w = idx;
        fwdata = 32'd0;
        vwdata = '0;
        if (state_reg == S_CLR)
            fwe = 1'b1;
        if (state_reg == S_WR)
        begin
            vwe = 1'b1;
            vwdata = item_reg.first_locus ? 102'(em) : acc_reg;
        end
        if (state_reg == S_OUT && out_ready_ok)
        begin
            fwe = 1'b1;
            fwdata = zero_reg ? 32'd0 : q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg <= '0;
            cfg_reg <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == 1'(CfgPanels))
                cfg_reg <= pwdata[6:0];
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (AW+1)'(MAX_PANEL - 1))
                    begin
                        state_reg <= S_IDLE;
                        idx_reg <= '0;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        n_reg <= n_eff;
                        idx_reg <= '0;
                        total_reg <= '0;
                        sum_reg <= '0;
                        state_reg <= in_data.first_locus ? S_RD : S_SUMR;
                    end
                end
                S_SUMR: state_reg <= S_SUMA;
                S_SUMA:
                begin
                    total_reg <= total_reg + 38'(frdata);
                    if (last)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_MASS;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SUMR;
                    end
                end
                S_MASS:
                begin
                    // upper total bits carry weight 2^32, so the product doubles
                    mass_reg <= 69'({mp[37:0], 1'b0});
                    state_reg <= S_M1B;
                end
                S_M1B:
                begin
                    mass_reg <= mass_reg + 69'(mp >> 31);
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= item_reg.first_locus ? S_WR : S_M1;
                S_M1:
                begin
                    term_reg <= 70'(mp >> 31) + 70'(mass_reg);
                    acc_reg <= '0;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg <= 102'(mp >> 31);
                    state_reg <= S_M2B;
                end
                S_M2B:
                begin
                    acc_reg <= acc_reg + ({38'd0, mp} << 1);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    acc_reg <= acc_reg + ({38'd0, mp} << 33);
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    sum_reg <= sum_reg + 70'(item_reg.first_locus ? 102'(em) : acc_reg);
                    if (last)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_DIVR;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DIVR:
                begin
                    zero_reg <= (sum_reg == '0);
                    state_reg <= S_DIV;
                    bit_reg <= '0;
                    q_reg <= '0;
                    rem_reg <= '0;
                end
                S_DIV:
                begin
                    // restoring division of v * 2^31 by sum, v <= sum
                    if (bit_reg == 6'd0)
                        rem_reg <= vrdata;
                    else if (!trial[102])
                    begin
                        rem_reg <= trial[101:0];
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[100:0], 1'b0};
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    if (bit_reg == 6'd0 && vrdata >= 102'(sum_reg) && sum_reg != '0)
                    begin
                        rem_reg <= vrdata - 102'(sum_reg);
                        q_reg <= 32'd1;
                    end
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 6'd31)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.hap_index <= 6'(idx);
                        out_reg.forward_prob <= zero_reg ? 32'd0 : q_reg;
                        out_reg.zero_mass <= zero_reg;
                        out_reg.last_of_locus <= last;
                        if (last)
                        begin
                            idx_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_DIVR;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'(CfgPanels)) ? {25'd0, cfg_reg} : 32'd0;

    // divider only runs on a nonzero sum or its result is masked
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_mass |-> out_data.forward_prob == 32'd0)
        else $error("zero mass with nonzero prob");
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.forward_prob <= 32'h8000_0000)
        else $error("prob above one");
endmodule

// ===== hw/rtl/hchmm_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
module hchmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== verif/hchmm_forward_checker.sv =====
// scoreboard for the haplotype-copy hmm forward block: predicts every locus and checks results
// depends on hchmm_pkg; watches the input, output and apb channels of the block
`timescale 1ns / 100ps

module hchmm_forward_checker
    import hchmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int NumHaps = 64;

    logic [31:0] fwd_mem [NumHaps];
    logic [6:0]  panels_reg;
    out_item_t   hap_results_q [$];

    assign pending = hap_results_q.size();

    // floor(a * b / 2^31), exact
    function automatic logic [127:0] q31_mul(logic [127:0] a, logic [127:0] b);
        return (a * b) >> 31;
    endfunction

    task automatic predict_locus(in_item_t it);
        int            n;
        logic [127:0]  total;
        logic [127:0]  mass;
        logic [127:0]  sum;
        logic [127:0]  em;
        logic [127:0]  vals [NumHaps];
        logic [127:0]  p;
        out_item_t     r;
        n = int'(panels_reg);
        if (n == 0)
            n = 1;
        if (n > NumHaps)
            n = NumHaps;
        total = 0;
        mass = 0;
        sum = 0;
        if (!it.first_locus)
        begin
            for (int i = 0; i < n; i++)
                total += 128'(fwd_mem[i]);
            mass = q31_mul(128'(it.switch_prob), total);
        end
        for (int i = 0; i < n; i++)
        begin
            em = 128'(it.panel_alleles[i] ? it.emission_alt : it.emission_ref);
            if (it.first_locus)
                vals[i] = em;
            else
                vals[i] = q31_mul(em, q31_mul(128'(it.stay_prob), 128'(fwd_mem[i])) + mass);
            sum += vals[i];
        end
        for (int i = 0; i < n; i++)
        begin
            p = (sum == 0) ? 128'd0 : (vals[i] << 31) / sum;
            fwd_mem[i] = p[31:0];
            r.hap_index = i[5:0];
            r.forward_prob = p[31:0];
            r.zero_mass = (sum == 0);
            r.last_of_locus = (i + 1 == n);
            hap_results_q = {hap_results_q, r};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NumHaps; i++)
                fwd_mem[i] = '0;
            panels_reg = 7'd64;
            hap_results_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 3'(4 * CfgPanels))
                panels_reg = pwdata[6:0];
            if (in_valid && in_ready)
                predict_locus(in_data);
            if (out_valid && out_ready)
            begin
                if (hap_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = hap_results_q.pop_front();
                    if (want.hap_index !== out_data.hap_index)
                    begin
                        $display("%0t: hap_index expected %0d actual %0d", $time,
                                 want.hap_index, out_data.hap_index);
                        fail_count++;
                    end
                    if (want.forward_prob !== out_data.forward_prob)
                    begin
                        $display("%0t: forward_prob expected %h actual %h", $time,
                                 want.forward_prob, out_data.forward_prob);
                        fail_count++;
                    end
                    if (want.zero_mass !== out_data.zero_mass)
                    begin
                        $display("%0t: zero_mass expected %b actual %b", $time,
                                 want.zero_mass, out_data.zero_mass);
                        fail_count++;
                    end
                    if (want.last_of_locus !== out_data.last_of_locus)
                    begin
                        $display("%0t: last_of_locus expected %b actual %b", $time,
                                 want.last_of_locus, out_data.last_of_locus);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/haplotype_copy_hmm_forward_tb.sv =====
// top of the haplotype-copy hmm forward testbench: clock, reset, stimulus and verdict
// depends on hchmm_pkg, haplotype_copy_hmm_forward and hchmm_forward_checker
`timescale 1ns / 100ps

module haplotype_copy_hmm_forward_tb;
    import hchmm_pkg::*;

    localparam int StallLimit = 20000;
    localparam int LongHold = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    bit          calm;
    int          out_total;
    int          stall_left;
    bit          hold_done;
    int          quiet_cycles;

    haplotype_copy_hmm_forward dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hchmm_forward_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver: random stall bursts, one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
            out_total <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_total <= out_total + 1;
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
            else if (!hold_done && out_total >= 150)
            begin
                hold_done <= 1'b1;
                stall_left <= LongHold;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(1, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on the input or output channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_locus(in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_emission();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_prob();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    function automatic in_item_t rand_locus(bit first);
        in_item_t it;
        it.emission_ref = rand_emission();
        it.emission_alt = rand_emission();
        case ($urandom_range(0, 7))
            0: it.panel_alleles = '0;
            1: it.panel_alleles = '1;
            default: it.panel_alleles = {$urandom, $urandom};
        endcase
        it.switch_prob = rand_prob();
        it.stay_prob = rand_prob();
        it.first_locus = first;
        return it;
    endfunction

    function automatic in_item_t make_locus(logic [31:0] er, logic [31:0] ea, logic [63:0] al,
                                             logic [31:0] sw, logic [31:0] st, logic first);
        in_item_t it;
        it.emission_ref = er;
        it.emission_alt = ea;
        it.panel_alleles = al;
        it.switch_prob = sw;
        it.stay_prob = st;
        it.first_locus = first;
        return it;
    endfunction

    // segments: a first locus and a run of continuations, plus some stray continuations
    task automatic random_phase(logic [31:0] panels, int count, bit quiet);
        int sent;
        int seg_len;
        apb_write(3'(4 * CfgPanels), panels);
        calm = quiet;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_locus(rand_locus(1'b0));
                sent++;
            end
            else
            begin
                seg_len = $urandom_range(1, 7);
                send_locus(rand_locus(1'b1));
                sent++;
                for (int k = 0; k < seg_len && sent < count; k++)
                begin
                    send_locus(rand_locus(1'b0));
                    sent++;
                end
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset count of 64
        send_locus(make_locus(32'd5, 32'd7, {$urandom, $urandom}, 32'h4000_0000,
                              32'h4000_0000, 1'b0));
        send_locus(make_locus('1, '1, '1, 32'd0, 32'd0, 1'b1));
        send_locus(make_locus(32'd3, 32'd9, 64'h0F0F_0F0F_0F0F_0F0F, 32'd0,
                              32'h8000_0000, 1'b0));
        send_locus(make_locus('1, 32'd1, 64'h5555_5555_5555_5555, 32'h8000_0000,
                              32'd0, 1'b0));
        send_locus(make_locus('1, '1, 64'hAAAA_AAAA_AAAA_AAAA, '1, '1, 1'b0));
        send_locus(make_locus(32'd0, 32'd0, {$urandom, $urandom}, 32'd100, 32'd100, 1'b1));
        send_locus(make_locus(32'd77, 32'd88, {$urandom, $urandom}, 32'h8000_0000,
                              32'h8000_0000, 1'b0));
        send_locus(make_locus(32'd1, '1, 64'h5555_5555_5555_5555, 32'd0, 32'd0, 1'b1));
        send_locus(rand_locus(1'b0));
        send_locus(make_locus('1, 32'd0, 64'd0, 32'h0123_4567, 32'h7654_3210, 1'b1));
        send_locus(make_locus('1, '1, '1, 32'd0, 32'd0, 1'b0));
        send_locus(make_locus(32'd2, 32'd1, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 32'd0, 1'b1));
        send_locus(make_locus(32'd0, '1, 64'h8000_0000_0000_0001, 32'h8000_0000,
                              32'h8000_0000, 1'b0));
        drain();

        random_phase(32'd3, 40, 1'b0);
        random_phase(32'd1, 25, 1'b0);
        random_phase(32'd0, 15, 1'b0);
        random_phase(32'd127, 8, 1'b0);
        random_phase(32'd2, 40, 1'b0);
        random_phase(32'd64, 10, 1'b0);
        random_phase(32'd9, 40, 1'b1);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
